// ----- rtl/core/sbpr_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpr_pkg
// Shared types, constants and codes of the spectrum bar and peak renderer.
// ----------------------------------------------------------------------------
package sbpr_pkg;

  // Sizes
  localparam int NUM_BANDS_DEF = 16;
  localparam int BAND_W        = 4;
  localparam int MAG_W         = 8;
  localparam int PIX_W         = 10;
  localparam int GAIN_W        = 9;
  localparam int STEP_W        = 16;
  localparam int LEVEL_W       = 18;   // Q10.8 pixels
  localparam int COLOR_W       = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_CMDS      = 3;
  localparam int CNT_W         = 2;

  // Request kinds
  localparam logic REQ_BAND    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Color kinds
  localparam logic [COLOR_W-1:0] COLOR_BAND  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_BG    = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd2;

  // Peak marker thickness
  localparam logic [PIX_W-1:0] PEAK_H = 10'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAR_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_PITCH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL_STEP = 3'd7;

  // Register reset values
  localparam logic [PIX_W-1:0]  RST_SCREEN_HEIGHT  = 10'd240;
  localparam logic [PIX_W-1:0]  RST_MAX_BAR_HEIGHT = 10'd220;
  localparam logic [PIX_W-1:0]  RST_BAR_PITCH      = 10'd15;
  localparam logic [PIX_W-1:0]  RST_BAR_WIDTH      = 10'd12;
  localparam logic [PIX_W-1:0]  RST_X_OFFSET       = 10'd0;
  localparam logic [GAIN_W-1:0] RST_ATTACK_GAIN    = 9'd154;
  localparam logic [GAIN_W-1:0] RST_DECAY_GAIN     = 9'd64;
  localparam logic [STEP_W-1:0] RST_PEAK_FALL_STEP = 16'd676;

  typedef struct packed {
    logic [PIX_W-1:0]  screen_height;
    logic [PIX_W-1:0]  max_bar_height;
    logic [PIX_W-1:0]  bar_pitch;
    logic [PIX_W-1:0]  bar_width;
    logic [PIX_W-1:0]  x_offset;
    logic [GAIN_W-1:0] attack_gain;
    logic [GAIN_W-1:0] decay_gain;
    logic [STEP_W-1:0] peak_fall_step;
  } sbpr_cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  magnitude;
  } sbpr_req_t;

  typedef struct packed {
    logic               full_screen;
    logic [PIX_W-1:0]   rect_x;
    logic [PIX_W-1:0]   rect_y;
    logic [PIX_W-1:0]   rect_width;
    logic [PIX_W-1:0]   rect_height;
    logic [COLOR_W-1:0] color_kind;
    logic [BAND_W-1:0]  band_out;
    logic               last;
  } sbpr_cmd_t;

  // One band table entry
  typedef struct packed {
    logic [LEVEL_W-1:0] bar_level;
    logic [LEVEL_W-1:0] peak_level;
    logic [PIX_W-1:0]   shown_bar;
    logic [PIX_W-1:0]   shown_peak;
  } sbpr_entry_t;

  // Command batch handed from the controller to the output buffer
  typedef struct packed {
    logic                         load;
    logic [CNT_W-1:0]             count;
    sbpr_cmd_t [MAX_CMDS-1:0]     cmds;
  } sbpr_load_t;

endpackage

// ----- rtl/core/sbpr_chan_if.sv -----
// ----------------------------------------------------------------------------
// sbpr_chan_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface sbpr_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/sbpr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sbpr_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module sbpr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sbpr_pkg::sbpr_cfg_t             cfg
);
  import sbpr_pkg::*;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_height  <= RST_SCREEN_HEIGHT;
      cfg.max_bar_height <= RST_MAX_BAR_HEIGHT;
      cfg.bar_pitch      <= RST_BAR_PITCH;
      cfg.bar_width      <= RST_BAR_WIDTH;
      cfg.x_offset       <= RST_X_OFFSET;
      cfg.attack_gain    <= RST_ATTACK_GAIN;
      cfg.decay_gain     <= RST_DECAY_GAIN;
      cfg.peak_fall_step <= RST_PEAK_FALL_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT:  cfg.screen_height  <= cfg_wdata[PIX_W-1:0];
        CFG_MAX_BAR_HEIGHT: cfg.max_bar_height <= cfg_wdata[PIX_W-1:0];
        CFG_BAR_PITCH:      cfg.bar_pitch      <= cfg_wdata[PIX_W-1:0];
        CFG_BAR_WIDTH:      cfg.bar_width      <= cfg_wdata[PIX_W-1:0];
        CFG_X_OFFSET:       cfg.x_offset       <= cfg_wdata[PIX_W-1:0];
        CFG_ATTACK_GAIN:    cfg.attack_gain    <= cfg_wdata[GAIN_W-1:0];
        CFG_DECAY_GAIN:     cfg.decay_gain     <= cfg_wdata[GAIN_W-1:0];
        CFG_PEAK_FALL_STEP: cfg.peak_fall_step <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sbpr_band_mem.sv -----
// ----------------------------------------------------------------------------
// sbpr_band_mem
// Band table: one entry per band, one port, registered read.
// ----------------------------------------------------------------------------
module sbpr_band_mem #(
  parameter  int NUM_BANDS = sbpr_pkg::NUM_BANDS_DEF,
  localparam int IDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      addr,
  input  sbpr_pkg::sbpr_entry_t wdata,
  output sbpr_pkg::sbpr_entry_t rdata
);
  import sbpr_pkg::*;

  sbpr_entry_t mem [NUM_BANDS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/sbpr_cmd_buf.sv -----
// ----------------------------------------------------------------------------
// sbpr_cmd_buf
// Holds the commands of one item and hands them out one word at a time.
// ----------------------------------------------------------------------------
module sbpr_cmd_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  sbpr_pkg::sbpr_load_t load,
  output logic                 empty,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output sbpr_pkg::sbpr_cmd_t  cmd_data
);
  import sbpr_pkg::*;

  sbpr_cmd_t        slots [MAX_CMDS];
  sbpr_cmd_t        slots_next [MAX_CMDS];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] head;

  assign empty     = (head == count);
  assign cmd_valid = !empty;
  assign cmd_data  = slots[head];

  // tag the final word of the batch
  always_comb begin
    for (int i = 0; i < MAX_CMDS; i++) begin
      slots_next[i]      = load.cmds[i];
      slots_next[i].last = (CNT_W'(i) == load.count - 1'b1);
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else if (load.load) begin
      count <= load.count;
      head  <= '0;
    end else if (cmd_valid && cmd_ready) begin
      head <= head + 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load.load) begin
      slots <= slots_next;
    end
  end

endmodule

// ----- rtl/core/sbpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbpr_ctrl
// Per-item sequencer: target scaling, smoothing, peak hold and command build
// around a read-modify-write of the band table.
// ----------------------------------------------------------------------------
module sbpr_ctrl #(
  parameter  int NUM_BANDS = sbpr_pkg::NUM_BANDS_DEF,
  localparam int IDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sbpr_pkg::sbpr_cfg_t   cfg,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  sbpr_pkg::sbpr_req_t   req_data,
  output logic                  mem_rd_en,
  output logic                  mem_wr_en,
  output logic [IDX_W-1:0]      mem_addr,
  output sbpr_pkg::sbpr_entry_t mem_wdata,
  input  sbpr_pkg::sbpr_entry_t mem_rdata,
  input  logic                  buf_empty,
  output sbpr_pkg::sbpr_load_t  load
);
  import sbpr_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TGT1   = 4'd1;
  localparam logic [3:0] ST_TGT2   = 4'd2;
  localparam logic [3:0] ST_TGT3   = 4'd3;
  localparam logic [3:0] ST_SMOOTH = 4'd4;
  localparam logic [3:0] ST_APPLY  = 4'd5;
  localparam logic [3:0] ST_PEAK   = 4'd6;
  localparam logic [3:0] ST_ROUND  = 4'd7;
  localparam logic [3:0] ST_SHOW   = 4'd8;
  localparam logic [3:0] ST_RST    = 4'd9;

  // level + 0.5, to whole pixels, clamped to the bar maximum
  function automatic logic [PIX_W-1:0] round_clamp(input logic [LEVEL_W-1:0] lvl,
                                                   input logic [PIX_W-1:0]   lim);
    logic [LEVEL_W:0] sum;
    logic [PIX_W:0]   pix;
    sum = {1'b0, lvl} + (LEVEL_W+1)'(128);
    pix = sum[LEVEL_W:8];
    return (pix > {1'b0, lim}) ? lim : pix[PIX_W-1:0];
  endfunction

  // h - v, floored at zero
  function automatic logic [PIX_W-1:0] top_at(input logic [PIX_W-1:0] h,
                                              input logic [PIX_W-1:0] v);
    return (v > h) ? '0 : h - v;
  endfunction

  // h - v - 1, floored at zero
  function automatic logic [PIX_W-1:0] top_above(input logic [PIX_W-1:0] h,
                                                 input logic [PIX_W-1:0] v);
    return (v >= h) ? '0 : h - v - 1'b1;
  endfunction

  logic [3:0]               state;
  logic [NUM_BANDS-1:0]     band_valid;
  sbpr_req_t                req_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     valid_r;
  logic [LEVEL_W-1:0]       p_r;
  logic [PIX_W:0]           q0_r;
  logic [LEVEL_W-1:0]       target_r;
  logic                     rise_r;
  logic [LEVEL_W+GAIN_W-1:0] prod_r;
  logic [LEVEL_W-1:0]       bar_new_r;
  logic [LEVEL_W-1:0]       peak_new_r;
  logic [PIX_W-1:0]         nbar_r;
  logic [PIX_W-1:0]         npeak_r;
  logic [PIX_W-1:0]         x_r;

  sbpr_entry_t              cur;
  logic                     band_ok;
  logic [LEVEL_W-1:0]       mag_prod;
  logic [BAND_W+PIX_W-1:0]  band_off;
  logic [LEVEL_W-1:0]       y;
  logic [LEVEL_W+8:0]       y257;
  logic [LEVEL_W:0]         q0_255;
  logic [LEVEL_W:0]         rem;
  logic [LEVEL_W-1:0]       target;
  logic                     rise;
  logic [LEVEL_W-1:0]       diff;
  logic [GAIN_W-1:0]        gain;
  logic [LEVEL_W+GAIN_W:0]  step_sum;
  logic [LEVEL_W+1:0]       step;
  logic [LEVEL_W+1:0]       bar_sum;
  logic [LEVEL_W-1:0]       maxq;
  logic [LEVEL_W-1:0]       bar_new;
  logic [LEVEL_W-1:0]       peak_new;
  logic                     e0;
  logic                     e1;
  logic                     e2;
  sbpr_cmd_t                c0;
  sbpr_cmd_t                c1;
  sbpr_cmd_t                c2;
  sbpr_cmd_t                rst_cmd;

  // table entry as seen by this item: a band not written since reset or the last restart reads zero
  assign cur = valid_r ? mem_rdata : '0;

  assign band_ok   = (32'(req_data.band) < NUM_BANDS);
  assign req_ready = (state == ST_IDLE);

  // memory port
  assign mem_rd_en = (state == ST_TGT1);
  assign mem_wr_en = (state == ST_SHOW) && buf_empty;
  assign mem_addr  = idx_r;
  assign mem_wdata = '{bar_level: bar_new_r, peak_level: peak_new_r,
                       shown_bar: nbar_r, shown_peak: npeak_r};

  // target = p + (p + 127) / 255 with p = magnitude * max_bar_height;
  // the quotient comes from y * 257 / 65536, one low at most
  assign mag_prod = {{PIX_W{1'b0}}, req_r.magnitude} * {{MAG_W{1'b0}}, cfg.max_bar_height};
  assign band_off = {{PIX_W{1'b0}}, req_r.band} * {{BAND_W{1'b0}}, cfg.bar_pitch};
  assign y        = p_r + LEVEL_W'(127);
  assign y257     = {9'd0, y} + {1'b0, y, 8'd0};
  assign q0_255   = {q0_r, 8'd0} - {{(LEVEL_W-PIX_W){1'b0}}, q0_r};
  assign rem      = {1'b0, y} - q0_255;
  assign target   = p_r + {{(LEVEL_W-PIX_W-1){1'b0}}, q0_r}
                  + {{(LEVEL_W-1){1'b0}}, (rem >= (LEVEL_W+1)'(255))};

  // smoothing toward the target
  assign rise = (target_r > cur.bar_level);
  assign diff = rise ? (target_r - cur.bar_level) : (cur.bar_level - target_r);
  assign gain = rise ? cfg.attack_gain : cfg.decay_gain;

  assign step_sum = {1'b0, prod_r} + (LEVEL_W+GAIN_W+1)'(128);
  assign step     = step_sum[LEVEL_W+GAIN_W:8];
  assign bar_sum  = {2'b00, cur.bar_level} + step;
  assign maxq     = {cfg.max_bar_height, 8'd0};

  always_comb begin
    if (rise_r) begin
      bar_new = (bar_sum > {2'b00, maxq}) ? maxq : bar_sum[LEVEL_W-1:0];
    end else begin
      bar_new = (step > {2'b00, cur.bar_level}) ? '0
              : cur.bar_level - step[LEVEL_W-1:0];
    end
  end

  // peak hold with fall
  always_comb begin
    if (bar_new_r > cur.peak_level) begin
      peak_new = bar_new_r;
    end else if (cur.peak_level > {2'b00, cfg.peak_fall_step}) begin
      peak_new = cur.peak_level - {2'b00, cfg.peak_fall_step};
    end else begin
      peak_new = '0;
    end
  end

  // candidate commands: bar delta, peak erase, peak draw
  always_comb begin
    c0 = '0;
    c0.rect_x     = x_r;
    c0.rect_width = cfg.bar_width;
    c0.band_out   = req_r.band;
    c1 = c0;
    c2 = c0;
    e0 = (nbar_r != cur.shown_bar);
    if (nbar_r > cur.shown_bar) begin
      c0.rect_y      = top_at(cfg.screen_height, nbar_r);
      c0.rect_height = nbar_r - cur.shown_bar;
      c0.color_kind  = COLOR_BAND;
    end else begin
      c0.rect_y      = top_at(cfg.screen_height, cur.shown_bar);
      c0.rect_height = cur.shown_bar - nbar_r;
      c0.color_kind  = COLOR_BG;
    end
    e1 = (cur.shown_peak != npeak_r);
    c1.rect_y      = top_above(cfg.screen_height, cur.shown_peak);
    c1.rect_height = PEAK_H;
    c1.color_kind  = (cur.shown_peak <= nbar_r) ? COLOR_BAND : COLOR_BG;
    e2 = (npeak_r > nbar_r);
    c2.rect_y      = top_above(cfg.screen_height, npeak_r);
    c2.rect_height = PEAK_H;
    c2.color_kind  = COLOR_WHITE;
    rst_cmd = '0;
    rst_cmd.full_screen = 1'b1;
    rst_cmd.color_kind  = COLOR_BG;
  end

  // batch to the output buffer, packed to the front
  always_comb begin
    load = '0;
    if (state == ST_RST) begin
      load.load    = buf_empty;
      load.count   = CNT_W'(1);
      load.cmds[0] = rst_cmd;
    end else if (state == ST_SHOW) begin
      load.load    = buf_empty;
      load.count   = {1'b0, e0} + {1'b0, e1} + {1'b0, e2};
      load.cmds[0] = e0 ? c0 : (e1 ? c1 : c2);
      load.cmds[1] = (e0 && e1) ? c1 : c2;
      load.cmds[2] = c2;
    end
  end

  // sequencer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      band_valid <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (req_data.req_type == REQ_RESTART) begin
              band_valid <= '0;
              state      <= ST_RST;
            end else if (band_ok) begin
              state <= ST_TGT1;
            end
          end
        end
        ST_TGT1:   state <= ST_TGT2;
        ST_TGT2:   state <= ST_TGT3;
        ST_TGT3:   state <= ST_SMOOTH;
        ST_SMOOTH: state <= ST_APPLY;
        ST_APPLY:  state <= ST_PEAK;
        ST_PEAK:   state <= ST_ROUND;
        ST_ROUND:  state <= ST_SHOW;
        ST_SHOW: begin
          if (buf_empty) begin
            band_valid[idx_r] <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        ST_RST: begin
          if (buf_empty) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req_data;
      idx_r <= IDX_W'(req_data.band);
    end
    if (state == ST_TGT1) begin
      p_r     <= mag_prod;
      x_r     <= cfg.x_offset + band_off[PIX_W-1:0];
      valid_r <= band_valid[idx_r];
    end
    if (state == ST_TGT2) begin
      q0_r <= y257[LEVEL_W+8:16];
    end
    if (state == ST_TGT3) begin
      target_r <= target;
    end
    if (state == ST_SMOOTH) begin
      rise_r <= rise;
      prod_r <= diff * gain;
    end
    if (state == ST_APPLY) begin
      bar_new_r <= bar_new;
    end
    if (state == ST_PEAK) begin
      peak_new_r <= peak_new;
      nbar_r     <= round_clamp(bar_new_r, cfg.max_bar_height);
    end
    if (state == ST_ROUND) begin
      npeak_r <= round_clamp(peak_new_r, cfg.max_bar_height);
    end
  end

endmodule

// ----- rtl/core/spectrum_bar_peak_renderer.sv -----
// ----------------------------------------------------------------------------
// spectrum_bar_peak_renderer
// Turns band magnitudes into smoothed bars with peak hold and emits delta
// rectangle commands for a display.
// ----------------------------------------------------------------------------
//   channel  dir  payload          words per item
//   req      in   sbpr_req_t       1
//   cmd      out  sbpr_cmd_t       0..3 (last set on the final word)
//   cfg_*    in   index + data     write only, taken every cycle
//
// A band update holds req.ready low from acceptance through the table read
// with the scaling multiply, target division, smoothing multiply, apply,
// peak, round, and write-back with the batch load. A restart holds ready low
// until its clear command is loaded. Commands drain from a 3-word buffer one
// word per cycle while cmd.ready is high, as the next item starts; write-back
// and batch load wait until the previous batch has fully drained, which
// stretches the item by the output stall. Reset is synchronous; it clears the
// band valid bits, the table itself is not swept.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_renderer #(
  parameter int NUM_BANDS = sbpr_pkg::NUM_BANDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sbpr_chan_if.sink                       req,
  sbpr_chan_if.source                     cmd
);
  import sbpr_pkg::*;

  localparam int IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  sbpr_cfg_t        cfg;
  logic             mem_rd_en;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_addr;
  sbpr_entry_t      mem_wdata;
  sbpr_entry_t      mem_rdata;
  logic             buf_empty;
  sbpr_load_t       load;

  sbpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sbpr_band_mem #(.NUM_BANDS(NUM_BANDS)) u_mem (
    .clk   (clk),
    .rd_en (mem_rd_en),
    .wr_en (mem_wr_en),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  sbpr_ctrl #(.NUM_BANDS(NUM_BANDS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_data  (req.data),
    .mem_rd_en (mem_rd_en),
    .mem_wr_en (mem_wr_en),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .buf_empty (buf_empty),
    .load      (load)
  );

  sbpr_cmd_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .empty     (buf_empty),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_data  (cmd.data)
  );

endmodule
